// File: sv/flv_tag_deframer_defines.svh
// Assertion helpers used by the parser module to check its own logic.
`ifndef FLV_TAG_DEFRAMER_DEFINES_SVH
`define FLV_TAG_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while reset is low.
`define FVTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while reset is low.
`define FVTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fvtd_pkg.sv
package fvtd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERSIZED = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd3;

  localparam logic [7:0] TYPE_AUDIO  = 8'd8;
  localparam logic [7:0] TYPE_VIDEO  = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;

  localparam logic [3:0] HDR_TYPE_IDX   = 4'd4;
  localparam logic [3:0] HDR_CHECK_IDX  = 4'd7;
  localparam logic [3:0] HDR_TS_EXT_IDX = 4'd11;
  localparam logic [3:0] HDR_LAST_IDX   = 4'd14;

  localparam logic [23:0] MAX_BODY_RESET = 24'(5 << 20);

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  tag_type;
    logic [23:0] body_len;
    logic [31:0] timestamp;
    logic [23:0] stream_num;
    logic [31:0] previous_size;
    logic [7:0]  body_byte;
    logic        last_body;
  } result_t;

endpackage

// File: sv/fvtd_in_stage.sv
module fvtd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_data_byte,
  output logic                in_stall,
  input  logic                out_blocked,
  output fvtd_pkg::byte_item_t item,
  output logic                fire
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       accept;

  assign in_stall = valid_r && out_blocked;
  assign accept   = in_valid && !in_stall;
  assign fire     = valid_r && !out_blocked;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data_byte;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;

endmodule

// File: sv/fvtd_parser.sv
`include "flv_tag_deframer_defines.svh"

module fvtd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  fvtd_pkg::byte_item_t item,
  input  logic [23:0]          max_body_len,
  output fvtd_pkg::result_t    res,
  output logic                 res_valid
);

  fvtd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [23:0] left_r, left_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] time_r, time_nxt;
  logic [23:0] stream_r, stream_nxt;
  logic [23:0] size_shift;
  logic [1:0]  chk_status;
  logic        last;
  logic [7:0]  b;
  logic        is_halt;
  logic        is_body;
  logic        is_hdr;
  logic        err_out;

  assign b          = item.data;
  assign last       = (left_r <= 24'd1);
  assign size_shift = {size_r[15:0], b};

  always_comb begin
    if (size_shift > max_body_len) begin
      chk_status = fvtd_pkg::ST_OVERSIZED;
    end else if (!(type_r inside {fvtd_pkg::TYPE_AUDIO, fvtd_pkg::TYPE_VIDEO,
                                  fvtd_pkg::TYPE_SCRIPT})) begin
      chk_status = fvtd_pkg::ST_BAD_TYPE;
    end else if (type_r != fvtd_pkg::TYPE_SCRIPT && size_shift == 24'd0) begin
      chk_status = fvtd_pkg::ST_ZERO_SIZE;
    end else begin
      chk_status = fvtd_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    left_nxt    = left_r;
    prev_nxt    = prev_r;
    type_nxt    = type_r;
    size_nxt    = size_r;
    time_nxt    = time_r;
    stream_nxt  = stream_r;
    res         = '0;
    res_valid   = 1'b0;
    case (phase_r)
      fvtd_pkg::PH_BODY: begin
        res.kind      = fvtd_pkg::KIND_BODY;
        res.body_byte = b;
        res.last_body = last;
        res_valid     = 1'b1;
        if (last) begin
          left_nxt  = 24'd0;
          phase_nxt = fvtd_pkg::PH_HEADER;
        end else begin
          left_nxt = left_r - 24'd1;
        end
      end
      fvtd_pkg::PH_HEADER: begin
        case (hdr_idx_r) inside
          [4'd0:4'd3]:              prev_nxt   = {prev_r[23:0], b};
          fvtd_pkg::HDR_TYPE_IDX:   type_nxt   = b;
          [4'd5:4'd7]:              size_nxt   = size_shift;
          [4'd8:4'd10]:             time_nxt   = {8'd0, time_r[15:0], b};
          fvtd_pkg::HDR_TS_EXT_IDX: time_nxt   = {b, time_r[23:0]};
          default:                  stream_nxt = {stream_r[15:0], b};
        endcase
        if (hdr_idx_r == fvtd_pkg::HDR_CHECK_IDX && chk_status != fvtd_pkg::ST_OK) begin
          res.kind          = fvtd_pkg::KIND_ERROR;
          res.status        = chk_status;
          res.tag_type      = type_r;
          res.body_len      = size_nxt;
          res.previous_size = prev_r;
          res_valid         = 1'b1;
          phase_nxt         = fvtd_pkg::PH_HALT;
        end else if (hdr_idx_r == fvtd_pkg::HDR_LAST_IDX) begin
          res.kind          = fvtd_pkg::KIND_HEADER;
          res.status        = fvtd_pkg::ST_OK;
          res.tag_type      = type_r;
          res.body_len      = size_r;
          res.timestamp     = time_r;
          res.stream_num    = stream_nxt;
          res.previous_size = prev_r;
          res_valid         = 1'b1;
          hdr_idx_nxt       = 4'd0;
          left_nxt          = size_r;
          phase_nxt         = (size_r != 24'd0) ? fvtd_pkg::PH_BODY : fvtd_pkg::PH_HEADER;
        end else begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
    if (!fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= fvtd_pkg::PH_HEADER;
      hdr_idx_r <= 4'd0;
      left_r    <= 24'd0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      left_r    <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prev_r   <= prev_nxt;
      type_r   <= type_nxt;
      size_r   <= size_nxt;
      time_r   <= time_nxt;
      stream_r <= stream_nxt;
    end
  end

  assign is_halt = (phase_r == fvtd_pkg::PH_HALT);
  assign is_body = (phase_r == fvtd_pkg::PH_BODY);
  assign is_hdr  = (phase_r == fvtd_pkg::PH_HEADER);
  assign err_out = res_valid && (res.kind == fvtd_pkg::KIND_ERROR);

  `FVTD_ASSERT_NEXT(a_halt_sticky, is_halt, is_halt, "halt left without reset")
  `FVTD_ASSERT_NOW(a_body_count, is_body, left_r != 24'd0, "body phase with no bytes left")
  `FVTD_ASSERT_NEXT(a_error_halts, err_out, is_halt, "error item did not halt")
  `FVTD_ASSERT_NOW(a_idx_range, is_hdr, hdr_idx_r <= fvtd_pkg::HDR_LAST_IDX, "index overrun")
  `FVTD_ASSERT_NOW(a_fire_valid, fire, item.valid, "fire with an empty input register")

endmodule

// File: sv/fvtd_out_stage.sv
module fvtd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              res_valid,
  input  fvtd_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output fvtd_pkg::result_t out_res,
  output logic              out_blocked
);

  logic              valid_r;
  logic              valid_nxt;
  fvtd_pkg::result_t res_r;

  assign out_blocked = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = res_valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: sv/flv_tag_deframer.sv
// FLV tag deframer: takes one stream byte per item and one item per clock cycle while
// in_stall is low. Each byte passes an input register, the header/body parser, and a
// result register, so throughput is set by the parser's update of its counters and
// shift registers. A 15-byte tag header yields one header item, every body byte yields
// one body item with last_body on the final one, and a failed size or type check after
// the body size field yields one error item, after which all input is dropped until
// reset. cfg_wdata written with cfg_we sets the largest body size allowed (5242880 after
// reset); write it only while the block is idle.
module flv_tag_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [7:0]  out_tag_type,
  output logic [23:0] out_body_len,
  output logic [31:0] out_timestamp,
  output logic [23:0] out_stream_num,
  output logic [31:0] out_previous_size,
  output logic [7:0]  out_body_byte,
  output logic        out_last_body
);

  logic [23:0]          max_body_len_r;
  fvtd_pkg::byte_item_t item;
  fvtd_pkg::result_t    res;
  fvtd_pkg::result_t    out_res;
  logic                 fire;
  logic                 res_valid;
  logic                 out_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_len_r <= fvtd_pkg::MAX_BODY_RESET;
    end else if (cfg_we) begin
      max_body_len_r <= cfg_wdata;
    end
  end

  fvtd_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .out_blocked  (out_blocked),
    .item         (item),
    .fire         (fire)
  );

  fvtd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (item),
    .max_body_len (max_body_len_r),
    .res          (res),
    .res_valid    (res_valid)
  );

  fvtd_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .res_valid   (res_valid),
    .res         (res),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .out_blocked (out_blocked)
  );

  assign out_kind          = out_res.kind;
  assign out_status        = out_res.status;
  assign out_tag_type      = out_res.tag_type;
  assign out_body_len      = out_res.body_len;
  assign out_timestamp     = out_res.timestamp;
  assign out_stream_num    = out_res.stream_num;
  assign out_previous_size = out_res.previous_size;
  assign out_body_byte     = out_res.body_byte;
  assign out_last_body     = out_res.last_body;

endmodule
